// ===== hw/rtl/azdms_pkg.sv =====
// azdms_pkg: shared types, widths and constants of the azimuth-to-dms block
// elaboration-time functions build the cordic arctangent steps in turn units
// no dependencies
package azdms_pkg;

    localparam int DELTA_W    = 32;
    localparam int NORM_W     = 60;
    localparam int NORM_STEPS = 6;
    localparam int CORDIC_W   = 64;
    localparam int GUARD      = 8;
    localparam int DEG_W      = 9;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int TDATA_S_W  = 64;
    localparam int TDATA_M_W  = 24;

    localparam int ANG_LO_W = 20;
    localparam int SCALE_W  = 21;
    localparam logic [SCALE_W-1:0] DMS_SCALE = 21'd1296000;

    localparam int TOTAL_SEC_W = 21;
    localparam int DEG_PROD_W  = 44;
    localparam int DEG_SHIFT   = 34;
    localparam logic [22:0] DEG_RECIP = 23'd4772186;
    localparam logic [TOTAL_SEC_W-1:0] SEC_PER_DEG = 21'd3600;

    localparam int REM_W       = 12;
    localparam int MIN_PROD_W  = 25;
    localparam int MIN_SHIFT   = 18;
    localparam logic [12:0] MIN_RECIP = 13'd4370;
    localparam logic [REM_W-1:0] SEC_PER_MIN = 12'd60;

    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
    } azdms_side_t;

    typedef struct packed {
        logic [SEC_W-1:0] seconds;
        logic [MIN_W-1:0] minutes;
        logic [DEG_W-1:0] degrees;
    } azdms_res_t;

    // shift-subtract division, used only while elaborating constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            q = {q[62:0], 1'b0};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in unsigned q60 radians
    function automatic logic [63:0] atan_inv_q60(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic done;
        p = udiv64(ONE_Q60, n);
        sum = p;
        done = 1'b0;
        for (int k = 1; k < 64; k++) begin
            if (!done) begin
                p = udiv64(p, n * n);
                if (p == 64'd0) begin
                    done = 1'b1;
                end else if (k % 2 == 1) begin
                    sum = sum - udiv64(p, 64'(2 * k + 1));
                end else begin
                    sum = sum + udiv64(p, 64'(2 * k + 1));
                end
            end
        end
        return sum;
    endfunction

    // atan(2^-i) in unsigned q60 radians
    function automatic logic [63:0] atan_pow2_q60(input int i, input logic [63:0] pi_q60);
        logic [63:0] sum;
        logic [63:0] t;
        int sh;
        sum = '0;
        if (i == 0) begin
            return pi_q60 >> 2;
        end
        for (int k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (sh <= 60) begin
                t = udiv64(64'd1 << (60 - sh), 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - t;
                end else begin
                    sum = sum + t;
                end
            end
        end
        return sum;
    endfunction

    // atan(2^-i) as a fraction of a turn with g bits, rounded to nearest
    function automatic logic [63:0] atan_turn(input int i, input int g);
        logic [63:0] pi_q60;
        logic [63:0] two_pi;
        logic [63:0] r;
        logic [63:0] q;
        pi_q60 = 64'd16 * atan_inv_q60(64'd5) - 64'd4 * atan_inv_q60(64'd239);
        two_pi = pi_q60 << 1;
        r = atan_pow2_q60(i, pi_q60);
        q = '0;
        for (int b = 0; b < g; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= two_pi) begin
                r = r - two_pi;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= two_pi) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

endpackage

// ===== hw/rtl/azdms_norm_cell.sv =====
// azdms_norm_cell: one step of the normalizing shifter chain
// shifts both magnitudes left by SHIFT when their top SHIFT bits are clear
// depends on azdms_pkg
module azdms_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [azdms_pkg::NORM_W-1:0]   in_x,
    input  logic [azdms_pkg::NORM_W-1:0]   in_y,
    input  azdms_pkg::azdms_side_t         in_side,
    output logic                           out_valid,
    output logic [azdms_pkg::NORM_W-1:0]   out_x,
    output logic [azdms_pkg::NORM_W-1:0]   out_y,
    output azdms_pkg::azdms_side_t         out_side
);

    logic                         valid_reg;
    logic [azdms_pkg::NORM_W-1:0] x_reg;
    logic [azdms_pkg::NORM_W-1:0] y_reg;
    azdms_pkg::azdms_side_t       side_reg;
    logic [azdms_pkg::NORM_W-1:0] both;
    logic                         do_shift;

    assign both     = in_x | in_y;
    assign do_shift = (both[azdms_pkg::NORM_W-1 -: SHIFT] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= do_shift ? (in_x << SHIFT) : in_x;
            y_reg    <= do_shift ? (in_y << SHIFT) : in_y;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_side  = side_reg;

endmodule

// ===== hw/rtl/azdms_cordic_cell.sv =====
// azdms_cordic_cell: one vectoring micro-rotation of the cordic chain
// rotates (x, y) toward the x axis and accumulates the turn angle in z
// depends on azdms_pkg
module azdms_cordic_cell #(
    parameter int          STAGE     = 0,
    parameter int          ZW        = 41,
    parameter logic [63:0] ATAN_STEP = 64'd0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [azdms_pkg::CORDIC_W-1:0]   in_x,
    input  logic [azdms_pkg::CORDIC_W-1:0]   in_y,
    input  logic [ZW-1:0]                    in_z,
    input  azdms_pkg::azdms_side_t           in_side,
    output logic                             out_valid,
    output logic [azdms_pkg::CORDIC_W-1:0]   out_x,
    output logic [azdms_pkg::CORDIC_W-1:0]   out_y,
    output logic [ZW-1:0]                    out_z,
    output azdms_pkg::azdms_side_t           out_side
);

    localparam logic [ZW-1:0] STEP = ATAN_STEP[ZW-1:0];

    logic                           valid_reg;
    logic [azdms_pkg::CORDIC_W-1:0] x_reg;
    logic [azdms_pkg::CORDIC_W-1:0] y_reg;
    logic [ZW-1:0]                  z_reg;
    azdms_pkg::azdms_side_t         side_reg;
    logic [azdms_pkg::CORDIC_W-1:0] x_sh;
    logic [azdms_pkg::CORDIC_W-1:0] y_sh;
    logic [azdms_pkg::CORDIC_W-1:0] x_next;
    logic [azdms_pkg::CORDIC_W-1:0] y_next;
    logic [ZW-1:0]                  z_next;

    assign x_sh = in_x >> STAGE;
    assign y_sh = azdms_pkg::CORDIC_W'($signed(in_y) >>> STAGE);

    always_comb begin
        if (!in_y[azdms_pkg::CORDIC_W-1]) begin
            x_next = in_x + y_sh;
            y_next = in_y - x_sh;
            z_next = in_z + STEP;
        end else begin
            x_next = in_x - y_sh;
            y_next = in_y + x_sh;
            z_next = in_z - STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// ===== hw/rtl/azdms_dms.sv =====
// azdms_dms: scales a turn fraction to whole arc seconds, then splits
// into degrees, minutes and seconds over a seven-stage pipeline
// depends on azdms_pkg
module azdms_dms #(
    parameter int ANGLE_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ANGLE_BITS-1:0]   in_ang,
    output logic                    out_valid,
    output azdms_pkg::azdms_res_t   out_res
);

    localparam int LO_W  = azdms_pkg::ANG_LO_W;
    localparam int HI_W  = ANGLE_BITS - LO_W;
    localparam int K_W   = azdms_pkg::SCALE_W;
    localparam int SUM_W = ANGLE_BITS + K_W;
    localparam int TS_W  = azdms_pkg::TOTAL_SEC_W;

    logic [6:0] valid_reg;

    // stage 1: low partial product
    logic [LO_W+K_W-1:0] plo1_reg;
    logic [HI_W-1:0]     hi1_reg;
    // stage 2: high partial product
    logic [LO_W+K_W-1:0] plo2_reg;
    logic [HI_W+K_W-1:0] phi2_reg;
    // stage 3: total seconds
    logic [SUM_W-1:0]    sum;
    logic [TS_W-1:0]     s3_reg;
    // stage 4: degrees
    logic [azdms_pkg::DEG_PROD_W-1:0] deg_prod;
    logic [TS_W-1:0]                  s4_reg;
    logic [azdms_pkg::DEG_W-1:0]      deg4_reg;
    // stage 5: seconds within the degree
    logic [TS_W-1:0]                  deg_sec;
    logic [TS_W-1:0]                  rem_next;
    logic [azdms_pkg::REM_W-1:0]      rem5_reg;
    logic [azdms_pkg::DEG_W-1:0]      deg5_reg;
    // stage 6: minutes
    logic [azdms_pkg::MIN_PROD_W-1:0] min_prod;
    logic [azdms_pkg::REM_W-1:0]      rem6_reg;
    logic [azdms_pkg::DEG_W-1:0]      deg6_reg;
    logic [azdms_pkg::MIN_W-1:0]      min6_reg;
    // stage 7: seconds
    logic [azdms_pkg::REM_W-1:0]      sec_next;
    azdms_pkg::azdms_res_t            res7_reg;

    assign sum      = {phi2_reg, {LO_W{1'b0}}} + SUM_W'(plo2_reg);
    assign deg_prod = azdms_pkg::DEG_PROD_W'(s3_reg) * azdms_pkg::DEG_PROD_W'(azdms_pkg::DEG_RECIP);
    assign deg_sec  = TS_W'(deg4_reg) * azdms_pkg::SEC_PER_DEG;
    assign rem_next = s4_reg - deg_sec;
    assign min_prod = azdms_pkg::MIN_PROD_W'(rem5_reg) * azdms_pkg::MIN_PROD_W'(azdms_pkg::MIN_RECIP);
    assign sec_next = rem6_reg - azdms_pkg::REM_W'(min6_reg) * azdms_pkg::SEC_PER_MIN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo1_reg <= (LO_W+K_W)'(in_ang[LO_W-1:0]) * (LO_W+K_W)'(azdms_pkg::DMS_SCALE);
            hi1_reg  <= in_ang[ANGLE_BITS-1:LO_W];

            plo2_reg <= plo1_reg;
            phi2_reg <= (HI_W+K_W)'(hi1_reg) * (HI_W+K_W)'(azdms_pkg::DMS_SCALE);

            s3_reg   <= sum[SUM_W-1:ANGLE_BITS];

            s4_reg   <= s3_reg;
            deg4_reg <= deg_prod[azdms_pkg::DEG_SHIFT +: azdms_pkg::DEG_W];

            rem5_reg <= rem_next[azdms_pkg::REM_W-1:0];
            deg5_reg <= deg4_reg;

            rem6_reg <= rem5_reg;
            deg6_reg <= deg5_reg;
            min6_reg <= min_prod[azdms_pkg::MIN_SHIFT +: azdms_pkg::MIN_W];

            res7_reg.degrees <= deg6_reg;
            res7_reg.minutes <= min6_reg;
            res7_reg.seconds <= sec_next[azdms_pkg::SEC_W-1:0];
        end
    end

    assign out_valid = valid_reg[6];
    assign out_res   = res7_reg;

endmodule

// ===== hw/rtl/azimuth_dms_from_offsets.sv =====
// azimuth_dms_from_offsets: full-circle azimuth of (delta_x, delta_y) in degrees, minutes, seconds
// one beat in per cycle while s_tready is high
// the pipeline is the input register, 6 normalizer cells, CORDIC_STAGES cordic cells,
// 2 quadrant stages, 7 scaling stages and the output register
// a two-entry output buffer holds results; s_tready is low only while it is full
// aresetn (synchronous, active low) empties the pipeline and the output buffer
module azimuth_dms_from_offsets #(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [azdms_pkg::TDATA_S_W-1:0]     s_tdata,   // delta_x[31:0], delta_y[63:32]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [azdms_pkg::TDATA_M_W-1:0]     m_tdata    // degrees[8:0], minutes[14:9], seconds[20:15]
);

    localparam int NW = azdms_pkg::NORM_W;
    localparam int CW = azdms_pkg::CORDIC_W;
    localparam int G_BITS = ANGLE_BITS + azdms_pkg::GUARD;
    localparam int ZW = G_BITS + 1;
    localparam int A_W = ZW - azdms_pkg::GUARD;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] THREE_QUARTER = HALF | QUARTER;
    localparam logic [ZW-1:0] ROUND_HALF = ZW'(1) << (azdms_pkg::GUARD - 1);

    logic en;
    logic skid_full_reg;

    // input stage: sign and magnitude
    logic [63:0]            x_ext;
    logic [63:0]            y_ext;
    logic [COORD_WIDTH-1:0] x_raw;
    logic [COORD_WIDTH-1:0] y_raw;
    logic [COORD_WIDTH-1:0] x_mag;
    logic [COORD_WIDTH-1:0] y_mag;
    azdms_pkg::azdms_side_t side_next;
    logic                   in_valid_reg;
    logic [NW-1:0]          x_in_reg;
    logic [NW-1:0]          y_in_reg;
    azdms_pkg::azdms_side_t side_in_reg;

    assign en = !skid_full_reg;
    assign s_tready = en;

    assign x_ext = 64'($signed(s_tdata[azdms_pkg::DELTA_W-1:0]));
    assign y_ext = 64'($signed(s_tdata[azdms_pkg::TDATA_S_W-1:azdms_pkg::DELTA_W]));
    assign x_raw = x_ext[COORD_WIDTH-1:0];
    assign y_raw = y_ext[COORD_WIDTH-1:0];
    assign x_mag = x_raw[COORD_WIDTH-1] ? (~x_raw + 1'b1) : x_raw;
    assign y_mag = y_raw[COORD_WIDTH-1] ? (~y_raw + 1'b1) : y_raw;

    always_comb begin
        side_next.x_neg  = x_raw[COORD_WIDTH-1];
        side_next.y_neg  = y_raw[COORD_WIDTH-1];
        side_next.x_zero = (x_raw == '0);
        side_next.y_zero = (y_raw == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_in_reg    <= NW'(x_mag);
            y_in_reg    <= NW'(y_mag);
            side_in_reg <= side_next;
        end
    end

    // normalizer chain
    logic [azdms_pkg::NORM_STEPS:0] nv;
    logic [NW-1:0]                  nx [azdms_pkg::NORM_STEPS+1];
    logic [NW-1:0]                  ny [azdms_pkg::NORM_STEPS+1];
    azdms_pkg::azdms_side_t         ns [azdms_pkg::NORM_STEPS+1];

    assign nv[0] = in_valid_reg;
    assign nx[0] = x_in_reg;
    assign ny[0] = y_in_reg;
    assign ns[0] = side_in_reg;

    for (genvar j = 0; j < azdms_pkg::NORM_STEPS; j++) begin : g_norm
        azdms_norm_cell #(
            .SHIFT(1 << (azdms_pkg::NORM_STEPS - 1 - j))
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (nv[j]),
            .in_x     (nx[j]),
            .in_y     (ny[j]),
            .in_side  (ns[j]),
            .out_valid(nv[j+1]),
            .out_x    (nx[j+1]),
            .out_y    (ny[j+1]),
            .out_side (ns[j+1])
        );
    end

    // cordic chain
    logic [CORDIC_STAGES:0]  cv;
    logic [CW-1:0]           cx [CORDIC_STAGES+1];
    logic [CW-1:0]           cy [CORDIC_STAGES+1];
    logic [ZW-1:0]           cz [CORDIC_STAGES+1];
    azdms_pkg::azdms_side_t  cs [CORDIC_STAGES+1];

    assign cv[0] = nv[azdms_pkg::NORM_STEPS];
    assign cx[0] = CW'(nx[azdms_pkg::NORM_STEPS]);
    assign cy[0] = CW'(ny[azdms_pkg::NORM_STEPS]);
    assign cz[0] = '0;
    assign cs[0] = ns[azdms_pkg::NORM_STEPS];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic [63:0] ATAN_I = azdms_pkg::atan_turn(i, G_BITS);
        azdms_cordic_cell #(
            .STAGE    (i),
            .ZW       (ZW),
            .ATAN_STEP(ATAN_I)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cv[i]),
            .in_x     (cx[i]),
            .in_y     (cy[i]),
            .in_z     (cz[i]),
            .in_side  (cs[i]),
            .out_valid(cv[i+1]),
            .out_x    (cx[i+1]),
            .out_y    (cy[i+1]),
            .out_z    (cz[i+1]),
            .out_side (cs[i+1])
        );
    end

    // first-quadrant angle: round off the guard bits and clamp
    logic [ZW-1:0]          z_round;
    logic [A_W-1:0]         a_wide;
    logic [ANGLE_BITS-1:0]  a_next;
    logic                   a_valid_reg;
    logic [ANGLE_BITS-1:0]  a_reg;
    azdms_pkg::azdms_side_t a_side_reg;

    assign z_round = cz[CORDIC_STAGES] + ROUND_HALF;
    assign a_wide  = z_round[ZW-1:azdms_pkg::GUARD];

    always_comb begin
        if (cz[CORDIC_STAGES][ZW-1]) begin
            a_next = '0;
        end else if (a_wide > A_W'(QUARTER)) begin
            a_next = QUARTER;
        end else begin
            a_next = a_wide[ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg      <= a_next;
            a_side_reg <= cs[CORDIC_STAGES];
        end
    end

    // quadrant placement and axis cases
    logic                  ang_valid_reg;
    logic [ANGLE_BITS-1:0] ang_reg;
    logic [ANGLE_BITS-1:0] ang_next;
    logic [ANGLE_BITS-1:0] a_eff;
    logic                  y_pos;

    assign a_eff = a_side_reg.y_zero ? '0 : a_reg;
    assign y_pos = !a_side_reg.y_neg && !a_side_reg.y_zero;

    always_comb begin
        priority if (a_side_reg.x_zero) begin
            if (a_side_reg.y_zero) begin
                ang_next = '0;
            end else if (a_side_reg.y_neg) begin
                ang_next = THREE_QUARTER;
            end else begin
                ang_next = QUARTER;
            end
        end else if (!a_side_reg.x_neg) begin
            ang_next = y_pos ? a_eff : ('0 - a_eff);
        end else begin
            ang_next = y_pos ? (HALF - a_eff) : (HALF + a_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_valid_reg <= 1'b0;
        end else if (en) begin
            ang_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= ang_next;
        end
    end

    // scaling to degrees, minutes, seconds
    logic                  dms_valid;
    azdms_pkg::azdms_res_t dms_res;

    azdms_dms #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_dms (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (ang_valid_reg),
        .in_ang   (ang_reg),
        .out_valid(dms_valid),
        .out_res  (dms_res)
    );

    // output register with skid entry
    logic                  out_valid_reg;
    azdms_pkg::azdms_res_t out_data_reg;
    azdms_pkg::azdms_res_t skid_data_reg;
    logic                  take;
    logic                  arrive;

    assign take   = out_valid_reg && m_tready;
    assign arrive = en && dms_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (take) begin
                skid_full_reg <= 1'b0;
            end
        end else if (arrive) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_full_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg && take) begin
            out_data_reg <= skid_data_reg;
        end else if (arrive && (!out_valid_reg || take)) begin
            out_data_reg <= dms_res;
        end
        if (arrive && out_valid_reg && !take) begin
            skid_data_reg <= dms_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = azdms_pkg::TDATA_M_W'(out_data_reg);

    // the skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry full with no result in the output register");

    // a full buffer stops the pipeline until the held beat drains
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full_reg && !m_tready) |=> (skid_full_reg && !s_tready))
        else $error("buffer drained without a beat being taken");

    // result fields stay in range
    a_dms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_data_reg.degrees < 9'd360 && out_data_reg.minutes < 6'd60
                      && out_data_reg.seconds < 6'd60))
        else $error("azimuth field out of range");

endmodule

// ===== tb/tb_azimuth_dms_from_offsets.sv =====
// tb_azimuth_dms_from_offsets: streams (delta_x, delta_y) beats into the azimuth block and
// checks each degrees/minutes/seconds beat against an in-bench cordic azimuth predictor
// depends on azdms_pkg and azimuth_dms_from_offsets
module tb_azimuth_dms_from_offsets;

    localparam int COORD_W   = 32;
    localparam int ANGLE_B   = 32;
    localparam int STAGES    = 24;
    localparam int GUARD_B   = 8;
    localparam int TURN_B    = ANGLE_B + GUARD_B;
    localparam int PIPE_LAT  = STAGES + 16;
    localparam int IDLE_PCT  = 36;
    localparam logic [63:0] Q60_ONE = 64'd1 << 60;

    typedef struct {
        logic [COORD_W-1:0]    dx;
        logic [COORD_W-1:0]    dy;
        azdms_pkg::azdms_res_t dms;
    } dms_expect_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [azdms_pkg::TDATA_S_W-1:0]     s_tdata = '0;   // delta_x[31:0], delta_y[63:32]
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [azdms_pkg::TDATA_M_W-1:0]     m_tdata;        // degrees[8:0], minutes[14:9], seconds[20:15]

    logic [63:0]           atan_turn_step [STAGES];
    dms_expect_t           pending_dms [$];
    dms_expect_t           want;
    azdms_pkg::azdms_res_t got_dms;
    int                    mismatch_cnt = 0;
    int                    pairs_sent = 0;
    int                    results_checked = 0;
    int                    in_stall_cycles = 0;
    int                    rx_hold_len = 0;
    bit                    tx_steady = 1'b0;
    bit                    rx_steady = 1'b0;

    azimuth_dms_from_offsets #(
        .COORD_WIDTH   (COORD_W),
        .ANGLE_BITS    (ANGLE_B),
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // atan(1/n) in q60 radians, alternating series
    function automatic logic [63:0] arctan_recip_q60(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        int k;
        p = Q60_ONE / n;
        sum = p;
        k = 1;
        while (k < 64) begin
            p = p / (n * n);
            if (p == 64'd0) begin
                k = 64;
            end else begin
                if (k % 2 == 1) begin
                    sum = sum - p / 64'(2 * k + 1);
                end else begin
                    sum = sum + p / 64'(2 * k + 1);
                end
                k++;
            end
        end
        return sum;
    endfunction

    // atan(2^-i) in q60 radians
    function automatic logic [63:0] arctan_pow2_q60(input int i, input logic [63:0] pi_q60);
        logic [63:0] sum;
        logic [63:0] t;
        int k;
        int sh;
        if (i == 0) begin
            return pi_q60 / 4;
        end
        sum = '0;
        k = 0;
        sh = i;
        while (k < 64 && sh <= 60) begin
            t = (64'd1 << (60 - sh)) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
                sum = sum - t;
            end else begin
                sum = sum + t;
            end
            k++;
            sh = i * (2 * k + 1);
        end
        return sum;
    endfunction

    function automatic void build_turn_steps();
        logic [63:0] pi_q60;
        logic [63:0] two_pi;
        logic [63:0] r;
        logic [63:0] q;
        pi_q60 = 64'd16 * arctan_recip_q60(64'd5) - 64'd4 * arctan_recip_q60(64'd239);
        two_pi = pi_q60 << 1;
        for (int i = 0; i < STAGES; i++) begin
            r = arctan_pow2_q60(i, pi_q60);
            q = '0;
            for (int b = 0; b < TURN_B; b++) begin
                r = r << 1;
                q = q << 1;
                if (r >= two_pi) begin
                    r = r - two_pi;
                    q = q | 64'd1;
                end
            end
            if ((r << 1) >= two_pi) begin
                q = q + 64'd1;
            end
            atan_turn_step[i] = q;
        end
    endfunction

    // first-quadrant angle of two nonzero magnitudes, in ANGLE_B turn units
    function automatic logic [63:0] first_quadrant_turns(input logic [63:0] xm,
                                                         input logic [63:0] ym);
        logic [63:0]        m;
        logic [63:0]        x;
        logic [63:0]        y;
        logic [63:0]        z;
        logic [63:0]        nx;
        logic [63:0]        y_shr;
        logic signed [63:0] y_sg;
        logic [63:0]        a;
        int                 msb;
        m = (xm > ym) ? xm : ym;
        msb = 0;
        while ((m >> msb) > 64'd1) begin
            msb++;
        end
        x = xm << (59 - msb);
        y = ym << (59 - msb);
        z = '0;
        for (int i = 0; i < STAGES; i++) begin
            y_sg = y;
            y_sg = y_sg >>> i;
            y_shr = y_sg;
            if (!y[63]) begin
                nx = x + y_shr;
                y = y - (x >> i);
                z = z + atan_turn_step[i];
            end else begin
                nx = x - y_shr;
                y = y + (x >> i);
                z = z - atan_turn_step[i];
            end
            x = nx;
        end
        if (z[63]) begin
            return 64'd0;
        end
        a = (z + (64'd1 << (GUARD_B - 1))) >> GUARD_B;
        return (a > (64'd1 << (ANGLE_B - 2))) ? (64'd1 << (ANGLE_B - 2)) : a;
    endfunction

    function automatic azdms_pkg::azdms_res_t azimuth_to_dms(input logic [COORD_W-1:0] dx,
                                                             input logic [COORD_W-1:0] dy);
        logic [63:0] full_turn;
        logic [63:0] half_turn;
        logic [63:0] quarter_turn;
        logic [63:0] xm;
        logic [63:0] ym;
        logic [63:0] a;
        logic [63:0] ang;
        logic [63:0] total_sec;
        logic        x_neg;
        logic        y_neg;
        logic        y_pos;
        azdms_pkg::azdms_res_t r;
        full_turn = 64'd1 << ANGLE_B;
        half_turn = full_turn >> 1;
        quarter_turn = full_turn >> 2;
        x_neg = dx[COORD_W-1];
        y_neg = dy[COORD_W-1];
        xm = x_neg ? ((64'd1 << COORD_W) - 64'(dx)) : 64'(dx);
        ym = y_neg ? ((64'd1 << COORD_W) - 64'(dy)) : 64'(dy);
        if (xm == 64'd0) begin
            ang = (ym == 64'd0) ? 64'd0 : (y_neg ? 64'd3 * quarter_turn : quarter_turn);
        end else begin
            a = (ym == 64'd0) ? 64'd0 : first_quadrant_turns(xm, ym);
            y_pos = !y_neg && ym != 64'd0;
            if (!x_neg) begin
                ang = y_pos ? a : ((full_turn - a) & (full_turn - 64'd1));
            end else begin
                ang = y_pos ? half_turn - a : half_turn + a;
            end
        end
        total_sec = (ang * 64'd1296000) >> ANGLE_B;
        r.degrees = 9'(total_sec / 64'd3600);
        r.minutes = 6'((total_sec / 64'd60) % 64'd60);
        r.seconds = 6'(total_sec % 64'd60);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 40) begin
            $display("mismatch: %s", msg);
        end
        mismatch_cnt++;
    endtask

    task automatic send_pair(input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
        dms_expect_t e;
        if (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dy, dx};
        do @(posedge aclk); while (!s_tready);
        e.dx = dx;
        e.dy = dy;
        e.dms = azimuth_to_dms(dx, dy);
        pending_dms.push_back(e);
        pairs_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_dms.size() != 0);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] v;
        case ($urandom_range(9))
            3, 4: begin
                v = $urandom >> $urandom_range(0, 31);
                return $urandom_range(1) ? -v : v;
            end
            5: begin
                v = $urandom_range(1, 64);
                return $urandom_range(1) ? -v : v;
            end
            6: return '0;
            7: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h8000_0001;
                    3: return 32'h0000_0001;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic test_axes_and_corners();
        logic [COORD_W-1:0] xs [24] = '{
            32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'hffff_ffff, 32'h1, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1,
            32'h8000_0000, 32'h1, 32'h3, 32'hffff_fffd, 32'h7fff_ffff};
        logic [COORD_W-1:0] ys [24] = '{
            32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
            32'h0, 32'h1, 32'h1, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h7fff_ffff,
            32'h1, 32'h8000_0000, 32'h4, 32'hffff_fffc, 32'hffff_ffff};
        for (int i = 0; i < 24; i++) begin
            send_pair(xs[i], ys[i]);
        end
    endtask

    task automatic test_random_pairs(input int count);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] d;
        for (int i = 0; i < count; i++) begin
            x = pick_coord();
            if ($urandom_range(9) == 0) begin
                // near the diagonals
                d = $urandom_range(0, 8);
                y = $urandom_range(1) ? x + d : -x - d;
            end else begin
                y = pick_coord();
            end
            send_pair(x, y);
        end
    endtask

    task automatic test_steady_stream(input int count);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        test_random_pairs(count);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_output_backpressure(input int count);
        tx_steady = 1'b1;
        rx_hold_len = 300;
        test_random_pairs(count);
        tx_steady = 1'b0;
    endtask

    task automatic test_drain_between_bursts(input int bursts, input int count);
        for (int b = 0; b < bursts; b++) begin
            test_random_pairs(count);
            wait_drained();
        end
    endtask

    // receiver: random stalls, a counted hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_len != 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge aclk);
                rx_hold_len = 0;
            end
            m_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready) begin
            in_stall_cycles++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_dms.size() == 0) begin
                report_mismatch($sformatf("result beat %h with nothing pending", m_tdata));
            end else begin
                want = pending_dms.pop_front();
                got_dms = m_tdata[20:0];
                if (got_dms.degrees != want.dms.degrees) begin
                    report_mismatch($sformatf("dx %h dy %h degrees %0d want %0d",
                        want.dx, want.dy, got_dms.degrees, want.dms.degrees));
                end
                if (got_dms.minutes != want.dms.minutes) begin
                    report_mismatch($sformatf("dx %h dy %h minutes %0d want %0d",
                        want.dx, want.dy, got_dms.minutes, want.dms.minutes));
                end
                if (got_dms.seconds != want.dms.seconds) begin
                    report_mismatch($sformatf("dx %h dy %h seconds %0d want %0d",
                        want.dx, want.dy, got_dms.seconds, want.dms.seconds));
                end
            end
        end
    end

    initial begin
        #800000;
        $display("tb_azimuth_dms_from_offsets NOT OK");
        $finish;
    end

    initial begin
        int waited;
        build_turn_steps();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_axes_and_corners();
        test_random_pairs(600);
        test_steady_stream(400);
        test_output_backpressure(200);
        test_drain_between_bursts(5, 40);
        test_random_pairs(400);

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_dms.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (PIPE_LAT + 10) @(posedge aclk);
        if (pending_dms.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_dms.size()));
        end

        $display("covered %0d offset pairs: axes, corners, full-range, scaled and diagonal",
                 pairs_sent);
        $display("%0d results checked, input stalled %0d cycles, %0d mismatches",
                 results_checked, in_stall_cycles, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("tb_azimuth_dms_from_offsets OK");
        end else begin
            $display("tb_azimuth_dms_from_offsets NOT OK");
        end
        $finish;
    end

endmodule
